// ===== design/kgp_pkg.sv =====
// Package for the keyed group text parser.
// Holds the word types, state codes, event codes and character constants
// shared by the front, queue, back and checker files.
package kgp_pkg;

  localparam int LINE_BITS = 16;
  localparam int QDEPTH    = 4;

  typedef enum logic [3:0] {
    EV_NAME_CHAR   = 4'd0,
    EV_GROUP_OPEN  = 4'd1,
    EV_KEY_CHAR    = 4'd2,
    EV_KEY_END     = 4'd3,
    EV_CAST_CHAR   = 4'd4,
    EV_VALUE_CHAR  = 4'd5,
    EV_ENTRY_DONE  = 4'd6,
    EV_GROUP_CLOSE = 4'd7,
    EV_ERROR       = 4'd8
  } kgp_ev_t;

  typedef enum logic [2:0] {
    LX_NORMAL = 3'd0,
    LX_SLASH  = 3'd1,
    LX_LINE   = 3'd2,
    LX_BLOCK  = 3'd3,
    LX_STAR   = 3'd4,
    LX_QUOTE  = 3'd5
  } kgp_lex_t;

  typedef enum logic [3:0] {
    PH_NAME_START = 4'd0,
    PH_NAME       = 4'd1,
    PH_OPEN       = 4'd2,
    PH_KEY_START  = 4'd3,
    PH_KEY        = 4'd4,
    PH_EQ         = 4'd5,
    PH_CAST_START = 4'd6,
    PH_CAST       = 4'd7,
    PH_VAL_START  = 4'd8,
    PH_VAL        = 4'd9,
    PH_SEMI       = 4'd10
  } kgp_phase_t;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_NL     = 8'h0A;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } kgp_in_t;

  typedef struct packed {
    kgp_ev_t     event_res;
    logic [7:0]  char_out;
    logic [15:0] line_number;
    logic        last;
  } kgp_out_t;

  // Results of one byte: one or two events sharing a line number.
  typedef struct packed {
    logic        two;
    kgp_ev_t     ev0;
    logic [7:0]  ch0;
    kgp_ev_t     ev1;
    logic [7:0]  ch1;
    logic [15:0] line;
  } kgp_bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } kgp_qstat_t;

endpackage

// ===== design/kgp_front.sv =====
// Front part: lexer and parser state machine, one byte per cycle while accepted.
// Produces a bundle of up to two events per byte; uses kgp_pkg.
module kgp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  kgp_pkg::kgp_in_t     in_word,
  output logic                 q_push,
  output kgp_pkg::kgp_bundle_t q_bundle
);

  localparam int LINE_W = (kgp_pkg::LINE_BITS > 16) ? kgp_pkg::LINE_BITS : 16;

  typedef struct packed {
    kgp_pkg::kgp_phase_t phase;
    logic                tok;
    logic                stopped;
    logic                to_quote;
  } pst_t;

  typedef struct packed {
    pst_t             st;
    logic             ev_v;
    kgp_pkg::kgp_ev_t ev;
    logic [7:0]       ch;
  } pout_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_alpha(c) || (c == kgp_pkg::CH_UNDER);
  endfunction

  function automatic pout_t emit(pout_t o, kgp_pkg::kgp_ev_t ev, logic [7:0] ch);
    pout_t r;
    r      = o;
    r.ev_v = 1'b1;
    r.ev   = ev;
    r.ch   = ch;
    return r;
  endfunction

  function automatic pout_t fail(pout_t o);
    pout_t r;
    r            = emit(o, kgp_pkg::EV_ERROR, 8'h00);
    r.st.stopped = 1'b1;
    return r;
  endfunction

  function automatic pout_t value_atom(pout_t o, logic [7:0] c);
    pout_t r;
    r = o;
    if (c == kgp_pkg::CH_QUOTE && !o.st.tok) begin
      r.st.to_quote = 1'b1;
    end else if (c == kgp_pkg::CH_SEMI) begin
      r          = emit(o, kgp_pkg::EV_ENTRY_DONE, 8'h00);
      r.st.phase = kgp_pkg::PH_KEY_START;
    end else if (is_alpha(c) || is_digit(c) || c == kgp_pkg::CH_MINUS ||
                 c == kgp_pkg::CH_UNDER) begin
      r        = emit(o, kgp_pkg::EV_VALUE_CHAR, c);
      r.st.tok = 1'b1;
    end else if (is_space(c)) begin
      r.st.phase = kgp_pkg::PH_SEMI;
    end else begin
      r = fail(o);
    end
    return r;
  endfunction

  function automatic pout_t parse_atom(pst_t s, logic [7:0] c);
    pout_t o;
    logic  sp;
    o.st          = s;
    o.st.to_quote = 1'b0;
    o.ev_v        = 1'b0;
    o.ev          = kgp_pkg::EV_NAME_CHAR;
    o.ch          = 8'h00;
    sp            = is_space(c);
    unique case (s.phase)
      kgp_pkg::PH_NAME_START: begin
        if (!sp) begin
          if (is_word(c)) begin
            o          = emit(o, kgp_pkg::EV_NAME_CHAR, c);
            o.st.phase = kgp_pkg::PH_NAME;
          end else begin
            o = fail(o);
          end
        end
      end
      kgp_pkg::PH_NAME: begin
        if (is_word(c)) begin
          o = emit(o, kgp_pkg::EV_NAME_CHAR, c);
        end else begin
          o.st.tok   = sp;
          o.st.phase = kgp_pkg::PH_OPEN;
        end
      end
      kgp_pkg::PH_OPEN: begin
        if (c == kgp_pkg::CH_LBRACE) begin
          o          = emit(o, kgp_pkg::EV_GROUP_OPEN, 8'h00);
          o.st.phase = kgp_pkg::PH_KEY_START;
          o.st.tok   = 1'b0;
        end else if (sp) begin
          o.st.tok = 1'b0;
        end else begin
          o = fail(o);
        end
      end
      kgp_pkg::PH_KEY_START: begin
        if (!sp) begin
          if (c == kgp_pkg::CH_RBRACE) begin
            o          = emit(o, kgp_pkg::EV_GROUP_CLOSE, 8'h00);
            o.st.phase = kgp_pkg::PH_NAME_START;
          end else if (is_word(c)) begin
            o          = emit(o, kgp_pkg::EV_KEY_CHAR, c);
            o.st.phase = kgp_pkg::PH_KEY;
          end else if (c == kgp_pkg::CH_EQUAL) begin
            o          = emit(o, kgp_pkg::EV_KEY_END, 8'h00);
            o.st.phase = kgp_pkg::PH_CAST_START;
          end else begin
            o = fail(o);
          end
        end
      end
      kgp_pkg::PH_KEY: begin
        if (is_word(c)) begin
          o = emit(o, kgp_pkg::EV_KEY_CHAR, c);
        end else if (sp) begin
          o          = emit(o, kgp_pkg::EV_KEY_END, 8'h00);
          o.st.phase = kgp_pkg::PH_EQ;
        end else if (c == kgp_pkg::CH_EQUAL) begin
          o          = emit(o, kgp_pkg::EV_KEY_END, 8'h00);
          o.st.phase = kgp_pkg::PH_CAST_START;
        end else begin
          o = fail(o);
        end
      end
      kgp_pkg::PH_EQ: begin
        if (!sp) begin
          if (c == kgp_pkg::CH_EQUAL) o.st.phase = kgp_pkg::PH_CAST_START;
          else o = fail(o);
        end
      end
      kgp_pkg::PH_CAST_START: begin
        if (!sp) begin
          if (c == kgp_pkg::CH_LPAREN) begin
            o.st.phase = kgp_pkg::PH_CAST;
          end else begin
            o.st.phase = kgp_pkg::PH_VAL;
            o.st.tok   = 1'b0;
            o          = value_atom(o, c);
          end
        end
      end
      kgp_pkg::PH_CAST: begin
        if (c == kgp_pkg::CH_RPAREN) o.st.phase = kgp_pkg::PH_VAL_START;
        else o = emit(o, kgp_pkg::EV_CAST_CHAR, c);
      end
      kgp_pkg::PH_VAL_START: begin
        o.st.phase = kgp_pkg::PH_VAL;
        o.st.tok   = 1'b0;
        if (!sp) o = value_atom(o, c);
      end
      kgp_pkg::PH_VAL: begin
        o = value_atom(o, c);
      end
      kgp_pkg::PH_SEMI: begin
        if (!sp) begin
          if (c == kgp_pkg::CH_SEMI) begin
            o          = emit(o, kgp_pkg::EV_ENTRY_DONE, 8'h00);
            o.st.phase = kgp_pkg::PH_KEY_START;
          end else begin
            o = fail(o);
          end
        end
      end
      default: o = fail(o);
    endcase
    return o;
  endfunction

  kgp_pkg::kgp_lex_t   lex_r, lex_nxt;
  kgp_pkg::kgp_phase_t phase_r, phase_nxt;
  logic                tok_r, tok_nxt;
  logic                stopped_r, stopped_nxt;
  logic                prev_sp_r, prev_sp_nxt;
  logic [kgp_pkg::LINE_BITS-1:0] line_r, line_nxt;

  pst_t        st0, st1, st2;
  pout_t       pa, pb;
  logic [7:0]  c;
  logic        a_take, b_take, norm, prev_a;
  logic        x_v;
  kgp_pkg::kgp_ev_t x_ev;
  logic [7:0]  x_ch;
  logic        a_res;
  logic [LINE_W-1:0] line_ext;
  logic [15:0] line_sat;

  assign c = in_word.in_byte;

  always_comb begin
    st0         = '{phase: phase_r, tok: tok_r, stopped: stopped_r, to_quote: 1'b0};
    st1         = st0;
    lex_nxt     = lex_r;
    prev_sp_nxt = prev_sp_r;
    line_nxt    = line_r;
    a_take      = 1'b0;
    b_take      = 1'b0;
    norm        = 1'b0;
    x_v         = 1'b0;
    x_ev        = kgp_pkg::EV_ERROR;
    x_ch        = 8'h00;
    pa          = parse_atom(st0, kgp_pkg::CH_SLASH);
    if (!stopped_r) begin
      if (in_word.end_of_file) begin
        if (lex_r == kgp_pkg::LX_SLASH) begin
          a_take      = 1'b1;
          st1         = pa.st;
          prev_sp_nxt = 1'b0;
        end
        if (!st1.stopped && !(st1.phase == kgp_pkg::PH_NAME_START ||
                              st1.phase == kgp_pkg::PH_NAME ||
                              (st1.phase == kgp_pkg::PH_OPEN && st1.tok))) begin
          x_v = 1'b1;
        end
        st1.stopped = 1'b1;
        lex_nxt     = kgp_pkg::LX_NORMAL;
      end else begin
        if (c == kgp_pkg::CH_NL && line_r != '1) begin
          line_nxt = line_r + 1'b1;
        end
        unique case (lex_r)
          kgp_pkg::LX_NORMAL: norm = 1'b1;
          kgp_pkg::LX_SLASH: begin
            if (c == kgp_pkg::CH_SLASH) begin
              lex_nxt = kgp_pkg::LX_LINE;
            end else if (c == kgp_pkg::CH_STAR) begin
              lex_nxt = kgp_pkg::LX_BLOCK;
            end else begin
              a_take      = 1'b1;
              st1         = pa.st;
              lex_nxt     = kgp_pkg::LX_NORMAL;
              prev_sp_nxt = 1'b0;
              norm        = !pa.st.stopped;
            end
          end
          kgp_pkg::LX_LINE: begin
            if (c == kgp_pkg::CH_NL) lex_nxt = kgp_pkg::LX_NORMAL;
          end
          kgp_pkg::LX_BLOCK: begin
            if (c == kgp_pkg::CH_STAR) lex_nxt = kgp_pkg::LX_STAR;
          end
          kgp_pkg::LX_STAR: begin
            lex_nxt = (c == kgp_pkg::CH_SLASH) ? kgp_pkg::LX_NORMAL : kgp_pkg::LX_BLOCK;
          end
          kgp_pkg::LX_QUOTE: begin
            if (c == kgp_pkg::CH_QUOTE) begin
              lex_nxt   = kgp_pkg::LX_NORMAL;
              st1.phase = kgp_pkg::PH_SEMI;
            end else begin
              x_v  = 1'b1;
              x_ev = kgp_pkg::EV_VALUE_CHAR;
              x_ch = c;
            end
          end
          default: lex_nxt = kgp_pkg::LX_NORMAL;
        endcase
      end
    end

    // second atom: the byte itself through whitespace folding
    prev_a = a_take ? 1'b0 : prev_sp_r;
    if (norm) begin
      if (c == kgp_pkg::CH_SLASH) begin
        lex_nxt = kgp_pkg::LX_SLASH;
      end else if (is_space(c)) begin
        if (!prev_a) begin
          prev_sp_nxt = 1'b1;
          b_take      = 1'b1;
        end
      end else begin
        prev_sp_nxt = 1'b0;
        b_take      = 1'b1;
      end
    end
    pb  = parse_atom(st1, c);
    st2 = st1;
    if (b_take) begin
      st2  = pb.st;
      x_v  = pb.ev_v;
      x_ev = pb.ev;
      x_ch = pb.ch;
      if (pb.st.to_quote) lex_nxt = kgp_pkg::LX_QUOTE;
    end
    phase_nxt   = st2.phase;
    tok_nxt     = st2.tok;
    stopped_nxt = st2.stopped;
  end

  assign line_ext = LINE_W'(line_nxt);
  assign line_sat = (line_ext > LINE_W'(16'hFFFF)) ? 16'hFFFF : line_ext[15:0];
  assign a_res    = a_take && pa.ev_v;

  always_comb begin
    q_bundle.line = line_sat;
    if (a_res) begin
      q_bundle.two = x_v;
      q_bundle.ev0 = pa.ev;
      q_bundle.ch0 = pa.ch;
      q_bundle.ev1 = x_ev;
      q_bundle.ch1 = x_ch;
    end else begin
      q_bundle.two = 1'b0;
      q_bundle.ev0 = x_ev;
      q_bundle.ch0 = x_ch;
      q_bundle.ev1 = x_ev;
      q_bundle.ch1 = x_ch;
    end
  end

  assign q_push = accept && (a_res || x_v);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lex_r     <= kgp_pkg::LX_NORMAL;
      phase_r   <= kgp_pkg::PH_NAME_START;
      tok_r     <= 1'b0;
      stopped_r <= 1'b0;
      prev_sp_r <= 1'b1;
      line_r    <= kgp_pkg::LINE_BITS'(1);
    end else if (accept) begin
      lex_r     <= lex_nxt;
      phase_r   <= phase_nxt;
      tok_r     <= tok_nxt;
      stopped_r <= stopped_nxt;
      prev_sp_r <= prev_sp_nxt;
      line_r    <= line_nxt;
    end
  end

endmodule

// ===== design/kgp_queue.sv =====
// Short register queue of event bundles between front and back.
// Uses kgp_pkg for the bundle type and depth.
module kgp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  kgp_pkg::kgp_bundle_t wdata,
  input  logic                 pop,
  output kgp_pkg::kgp_bundle_t head,
  output kgp_pkg::kgp_qstat_t  stat
);

  localparam int PW = $clog2(kgp_pkg::QDEPTH);
  localparam int CW = $clog2(kgp_pkg::QDEPTH + 1);

  kgp_pkg::kgp_bundle_t mem_r [kgp_pkg::QDEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign stat.full  = (cnt_r == CW'(kgp_pkg::QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? PW'(wp_r + 1'b1) : wp_r;
    rp_nxt  = do_pop ? PW'(rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end

endmodule

// ===== design/kgp_back.sv =====
// Back part: walks the head bundle one event per word and marks the last one.
// Uses kgp_pkg types.
module kgp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kgp_pkg::kgp_bundle_t head,
  input  kgp_pkg::kgp_qstat_t  qstat,
  input  logic                 pop,
  output logic                 q_pop,
  output logic                 empty,
  output kgp_pkg::kgp_out_t    out_word
);

  logic idx_r, idx_nxt;
  logic is_last, take;

  assign empty   = qstat.empty;
  assign is_last = !head.two || idx_r;
  assign take    = pop && !qstat.empty;
  assign q_pop   = take && is_last;

  always_comb begin
    out_word.event_res   = idx_r ? head.ev1 : head.ev0;
    out_word.char_out    = idx_r ? head.ch1 : head.ch0;
    out_word.line_number = head.line;
    out_word.last        = is_last;
    idx_nxt              = idx_r;
    if (take) idx_nxt = !is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= 1'b0;
    else idx_r <= idx_nxt;
  end

endmodule

// ===== design/keyed_group_text_parser.sv =====
// Keyed group text parser: one text byte per cycle in unless full, one event word
// per cycle out while popped and not empty. A byte's events enter the bundle queue
// when it is accepted. Throughput: one byte per cycle unless full; each byte yields
// 0 to 2 words, drained one per pop by the back part; a 4-entry bundle queue
// separates the two sides. Reset: synchronous, active low; parser back to awaiting
// a group name, line 1, queue empty.
module keyed_group_text_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  kgp_pkg::kgp_in_t  in_word,
  output logic              empty,
  input  logic              pop,
  output kgp_pkg::kgp_out_t out_word
);

  kgp_pkg::kgp_bundle_t fr_bundle, q_head;
  kgp_pkg::kgp_qstat_t  qstat;
  logic                 fr_push, q_pop, accept;

  assign full   = qstat.full;
  assign accept = push && !qstat.full;

  kgp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_word  (in_word),
    .q_push   (fr_push),
    .q_bundle (fr_bundle)
  );

  kgp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fr_push),
    .wdata (fr_bundle),
    .pop   (q_pop),
    .head  (q_head),
    .stat  (qstat)
  );

  kgp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (q_head),
    .qstat    (qstat),
    .pop      (pop),
    .q_pop    (q_pop),
    .empty    (empty),
    .out_word (out_word)
  );

endmodule

// ===== design/kgp_checker.sv =====
// Port-level checker for keyed_group_text_parser, attached by bind.
// Uses kgp_pkg event codes.
module kgp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input kgp_pkg::kgp_out_t out_word
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("results present or input blocked right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_word)))
    else $error("waiting result word changed");

  a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_word.event_res == kgp_pkg::EV_ERROR) |->
      (out_word.last && out_word.char_out == 8'h00))
    else $error("error word not final or carries a char");

  a_stop_after_err: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && out_word.event_res == kgp_pkg::EV_ERROR) |=> empty)
    else $error("result after error");

  a_mark_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_word.event_res == kgp_pkg::EV_GROUP_OPEN ||
                out_word.event_res == kgp_pkg::EV_KEY_END ||
                out_word.event_res == kgp_pkg::EV_ENTRY_DONE ||
                out_word.event_res == kgp_pkg::EV_GROUP_CLOSE)) |->
      (out_word.char_out == 8'h00 && out_word.line_number != 16'h0000))
    else $error("mark word carries a char or bad line");

endmodule

bind keyed_group_text_parser kgp_checker u_kgp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_word (out_word)
);
